// ===== rtl/core/sc2a_pkg.sv =====
// Package: scancode codes, key code constants and the translation table function.
`default_nettype none

package sc2a_pkg;

  localparam int unsigned CodeW   = 8;
  localparam int unsigned IdxW    = 7;
  localparam int unsigned SelW    = 2;
  localparam int unsigned RomAw   = SelW + IdxW;
  localparam int unsigned RomDepth = 384;

  typedef logic [CodeW-1:0] byte_t;
  typedef logic [SelW-1:0]  tsel_t;

  // Scancodes with a special meaning
  localparam byte_t ScLShift   = 8'd42;
  localparam byte_t ScRShift   = 8'd54;
  localparam byte_t ScLShiftUp = 8'd170;
  localparam byte_t ScRShiftUp = 8'd182;
  localparam byte_t ScCaps     = 8'd58;
  localparam byte_t ScNum      = 8'd69;
  localparam byte_t ScCtrl     = 8'd29;
  localparam byte_t ScAlt      = 8'd56;

  // Table selectors
  localparam tsel_t SelPlain  = 2'd0;
  localparam tsel_t SelShift  = 2'd1;
  localparam tsel_t SelKeypad = 2'd2;

  localparam byte_t KUnk = 8'd63;

  localparam byte_t PlainTab [128] = '{
    8'd63,  8'd128, 8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,
    8'd55,  8'd56,  8'd57,  8'd48,  8'd45,  8'd61,  8'd8,   8'd9,
    8'd113, 8'd119, 8'd101, 8'd114, 8'd116, 8'd121, 8'd117, 8'd105,
    8'd111, 8'd112, 8'd91,  8'd93,  8'd10,  8'd131, 8'd97,  8'd115,
    8'd100, 8'd102, 8'd103, 8'd104, 8'd106, 8'd107, 8'd108, 8'd59,
    8'd39,  8'd96,  8'd130, 8'd92,  8'd122, 8'd120, 8'd99,  8'd118,
    8'd98,  8'd110, 8'd109, 8'd44,  8'd46,  8'd47,  8'd130, 8'd42,
    8'd144, 8'd32,  8'd129, 8'd132, 8'd133, 8'd134, 8'd135, 8'd136,
    8'd137, 8'd138, 8'd139, 8'd140, 8'd141, 8'd162, 8'd150, 8'd153,
    8'd158, 8'd154, 8'd45,  8'd160, 8'd163, 8'd161, 8'd43,  8'd156,
    8'd159, 8'd157, 8'd152, 8'd155, 8'd10,  8'd63,  8'd63,  8'd142,
    8'd143, 8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,
    8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,
    8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,
    8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,
    8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63
  };

  // Shifted table differs from the plain one only below code 56
  localparam int unsigned ShiftSpan = 56;
  localparam byte_t ShiftTab [ShiftSpan] = '{
    8'd63,  8'd128, 8'd33,  8'd64,  8'd35,  8'd36,  8'd37,  8'd94,
    8'd38,  8'd42,  8'd40,  8'd41,  8'd95,  8'd43,  8'd8,   8'd9,
    8'd81,  8'd87,  8'd69,  8'd82,  8'd84,  8'd89,  8'd85,  8'd73,
    8'd79,  8'd80,  8'd123, 8'd125, 8'd10,  8'd131, 8'd65,  8'd83,
    8'd68,  8'd70,  8'd71,  8'd72,  8'd74,  8'd75,  8'd76,  8'd58,
    8'd34,  8'd126, 8'd130, 8'd124, 8'd90,  8'd88,  8'd67,  8'd86,
    8'd66,  8'd78,  8'd77,  8'd60,  8'd62,  8'd63,  8'd130, 8'd42
  };

  // Keypad table differs from the plain one for codes 71 to 83
  localparam int unsigned PadLo = 71;
  localparam int unsigned PadHi = 83;
  localparam byte_t PadTab [PadHi-PadLo+1] = '{
    8'd55, 8'd56, 8'd57, 8'd45, 8'd52, 8'd53, 8'd54, 8'd43,
    8'd49, 8'd50, 8'd51, 8'd48, 8'd46
  };

  function automatic byte_t key_lookup(tsel_t sel, logic [IdxW-1:0] idx);
    byte_t res;
    res = PlainTab[idx];
    if (sel == SelShift && 32'(idx) < ShiftSpan) begin
      res = ShiftTab[idx[5:0]];
    end else if (sel == SelKeypad && 32'(idx) >= PadLo && 32'(idx) <= PadHi) begin
      res = PadTab[4'(32'(idx) - PadLo)];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/scancode_to_ascii_translator.sv =====
// Top level: set-1 scancode to key code translator with table RAM and output skid.
`default_nettype none

// Takes one set-1 scancode byte per item and returns the key code for press
// codes, after the shift, caps-lock and num-lock keys have updated their flags.
// Modifier, lock and release bytes give no result. The three 128-entry key
// tables sit in a 384-entry RAM that is loaded from constants after reset;
// while it loads, s_axis_tready_o stays low. After that one item is taken
// every cycle unless the output side stalls; a result passes the RAM read
// register, then the output register, and a two-deep output stage (output
// register and skid) holds a read in flight while the downstream side stalls.
module scancode_to_ascii_translator (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [sc2a_pkg::CodeW-1:0] s_axis_tdata_i,  // [7:0] scancode
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [sc2a_pkg::CodeW-1:0]  m_axis_tdata_o       // [7:0] key_code
);

  import sc2a_pkg::*;

  localparam logic [RomAw-1:0] FillLast = RomAw'(RomDepth - 1);

  logic             filling_q;
  logic [RomAw-1:0] fill_q;
  logic             shift_q, shift_d;
  logic             caps_q, caps_d;
  logic             num_q, num_d;
  logic             s1_valid_q, s1_valid_d;
  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  byte_t            out_data_q, out_data_d;
  byte_t            skid_data_q, skid_data_d;
  byte_t            rdata;
  logic             accept;
  logic             produce;
  tsel_t            sel;
  logic [RomAw-1:0] raddr;

  // Table load after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filling_q <= 1'b1;
      fill_q    <= '0;
    end else if (filling_q) begin
      fill_q <= fill_q + RomAw'(1);
      if (fill_q == FillLast) begin
        filling_q <= 1'b0;
      end
    end
  end

  assign s_axis_tready_o = !filling_q && !skid_valid_q
                         && !(s1_valid_q && out_valid_q && !m_axis_tready_i);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // Flag update and table choice
  always_comb begin
    shift_d = shift_q;
    caps_d  = caps_q;
    num_d   = num_q;
    produce = 1'b0;
    if (accept) begin
      priority if (s_axis_tdata_i[CodeW-1]) begin
        if (s_axis_tdata_i == ScLShiftUp || s_axis_tdata_i == ScRShiftUp) begin
          shift_d = 1'b0;
        end
      end else if (s_axis_tdata_i == ScLShift || s_axis_tdata_i == ScRShift) begin
        shift_d = 1'b1;
      end else if (s_axis_tdata_i == ScCtrl || s_axis_tdata_i == ScAlt) begin
        produce = 1'b0;
      end else if (s_axis_tdata_i == ScCaps) begin
        caps_d = !caps_q;
      end else if (s_axis_tdata_i == ScNum) begin
        num_d = !num_q;
      end else begin
        produce = 1'b1;
      end
    end
  end

  always_comb begin
    priority if (num_q) begin
      sel = SelKeypad;
    end else if (shift_q || caps_q) begin
      sel = SelShift;
    end else begin
      sel = SelPlain;
    end
  end

  assign raddr = {sel, s_axis_tdata_i[IdxW-1:0]};

  sc2a_ram #(
    .Width(CodeW),
    .Depth(RomDepth)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (filling_q),
    .waddr_i(fill_q),
    .wdata_i(key_lookup(fill_q[RomAw-1:IdxW], fill_q[IdxW-1:0])),
    .re_i   (produce),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Output register and skid stage
  always_comb begin
    s1_valid_d   = produce;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || m_axis_tready_i) begin
      priority if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else if (s1_valid_q) begin
        out_valid_d = 1'b1;
        out_data_d  = rdata;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (s1_valid_q) begin
      skid_valid_d = 1'b1;
      skid_data_d  = rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q      <= 1'b0;
      caps_q       <= 1'b0;
      num_q        <= 1'b0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      shift_q      <= shift_d;
      caps_q       <= caps_d;
      num_q        <= num_d;
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Skid only fills behind a stalled output item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item while the output register is empty");

  // A read in flight never meets a full skid stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_valid_q && skid_valid_q))
    else $error("table read returned with nowhere to go");

  // No lookups or results while the table is being loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    filling_q |-> (!s1_valid_q && !out_valid_q))
    else $error("item moved during table load");

  // Key codes are never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q != '0))
    else $error("zero key code delivered");

endmodule

`default_nettype wire

// ===== rtl/core/sc2a_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module sc2a_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for the scancode to key code translator: directed and random typing with checks.
`timescale 1ns / 1ps

module tb;
  import sc2a_pkg::*;

  localparam int unsigned ItemsPerPhase = 470;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned CycleLimit    = 200000;

  localparam byte_t ReleaseBit  = 8'd128;
  localparam byte_t ExtPrefix   = 8'hE0;
  localparam byte_t ScEscape    = 8'd1;
  localparam byte_t ScQ         = 8'd16;
  localparam byte_t ScOne       = 8'd2;
  localparam byte_t ScSlash     = 8'd53;
  localparam byte_t ScPad7      = 8'd71;
  localparam byte_t ScPadDot    = 8'd83;
  localparam byte_t ScFirstFree = 8'd85;
  localparam byte_t ScSpace     = 8'd57;
  localparam int unsigned ShiftedSpan = 56;
  localparam int unsigned KeypadLo    = 71;
  localparam int unsigned KeypadHi    = 83;

  localparam byte_t PlainKeys [128] = '{
    8'd63,  8'd128, 8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,
    8'd55,  8'd56,  8'd57,  8'd48,  8'd45,  8'd61,  8'd8,   8'd9,
    8'd113, 8'd119, 8'd101, 8'd114, 8'd116, 8'd121, 8'd117, 8'd105,
    8'd111, 8'd112, 8'd91,  8'd93,  8'd10,  8'd131, 8'd97,  8'd115,
    8'd100, 8'd102, 8'd103, 8'd104, 8'd106, 8'd107, 8'd108, 8'd59,
    8'd39,  8'd96,  8'd130, 8'd92,  8'd122, 8'd120, 8'd99,  8'd118,
    8'd98,  8'd110, 8'd109, 8'd44,  8'd46,  8'd47,  8'd130, 8'd42,
    8'd144, 8'd32,  8'd129, 8'd132, 8'd133, 8'd134, 8'd135, 8'd136,
    8'd137, 8'd138, 8'd139, 8'd140, 8'd141, 8'd162, 8'd150, 8'd153,
    8'd158, 8'd154, 8'd45,  8'd160, 8'd163, 8'd161, 8'd43,  8'd156,
    8'd159, 8'd157, 8'd152, 8'd155, 8'd10,  8'd63,  8'd63,  8'd142,
    8'd143, 8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,
    8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,
    8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,
    8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,
    8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63,  8'd63
  };

  // Upper-case row: only the first 56 codes differ from the plain row
  localparam byte_t ShiftedKeys [ShiftedSpan] = '{
    8'd63,  8'd128, 8'd33,  8'd64,  8'd35,  8'd36,  8'd37,  8'd94,
    8'd38,  8'd42,  8'd40,  8'd41,  8'd95,  8'd43,  8'd8,   8'd9,
    8'd81,  8'd87,  8'd69,  8'd82,  8'd84,  8'd89,  8'd85,  8'd73,
    8'd79,  8'd80,  8'd123, 8'd125, 8'd10,  8'd131, 8'd65,  8'd83,
    8'd68,  8'd70,  8'd71,  8'd72,  8'd74,  8'd75,  8'd76,  8'd58,
    8'd34,  8'd126, 8'd130, 8'd124, 8'd90,  8'd88,  8'd67,  8'd86,
    8'd66,  8'd78,  8'd77,  8'd60,  8'd62,  8'd63,  8'd130, 8'd42
  };

  localparam byte_t KeypadKeys [KeypadHi-KeypadLo+1] = '{
    8'd55, 8'd56, 8'd57, 8'd45, 8'd52, 8'd53, 8'd54, 8'd43,
    8'd49, 8'd50, 8'd51, 8'd48, 8'd46
  };

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  s_axis_tvalid_i = 1'b0;
  logic  s_axis_tready_o;
  byte_t s_axis_tdata_i = '0;   // [7:0] scancode
  logic  m_axis_tvalid_o;
  logic  m_axis_tready_i = 1'b0;
  byte_t m_axis_tdata_o;        // [7:0] key_code

  logic shift_down;
  logic caps_on;
  logic num_on;

  byte_t       pending_keys [$];
  int unsigned key_errors = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  scancode_to_ascii_translator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Update the key flags for one scancode; return 1 when it yields a key code
  function automatic bit translate_scancode(input byte_t code, output byte_t key);
    key = '0;
    if ((code & ReleaseBit) != 0) begin
      if (code == ScLShiftUp || code == ScRShiftUp) begin
        shift_down = 1'b0;
      end
      return 1'b0;
    end
    if (code == ScLShift || code == ScRShift) begin
      shift_down = 1'b1;
      return 1'b0;
    end
    if (code == ScCtrl || code == ScAlt) begin
      return 1'b0;
    end
    if (code == ScCaps) begin
      caps_on = !caps_on;
      return 1'b0;
    end
    if (code == ScNum) begin
      num_on = !num_on;
      return 1'b0;
    end
    key = PlainKeys[code[6:0]];
    if (num_on) begin
      if (code >= KeypadLo && code <= KeypadHi) begin
        key = KeypadKeys[code - KeypadLo];
      end
    end else if ((shift_down || caps_on) && code < ShiftedSpan) begin
      key = ShiftedKeys[code];
    end
    return 1'b1;
  endfunction

  // Predict on every accepted scancode
  always @(posedge clk_i or negedge rst_ni) begin
    byte_t key;
    if (!rst_ni) begin
      shift_down = 1'b0;
      caps_on    = 1'b0;
      num_on     = 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      if (translate_scancode(s_axis_tdata_i, key)) begin
        pending_keys.push_back(key);
      end
    end
  end

  // Compare every accepted key code with the oldest prediction
  always @(posedge clk_i) begin
    byte_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_keys.size() == 0) begin
        key_errors++;
        $display("%0t: unexpected key code: expected none, actual %0d", $time,
                 m_axis_tdata_o);
      end else begin
        want = pending_keys.pop_front();
        if (m_axis_tdata_o !== want) begin
          key_errors++;
          $display("%0t: key_code mismatch: expected %0d, actual %0d", $time, want,
                   m_axis_tdata_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("[scancode_to_ascii_translator] ERROR");
    $finish;
  end

  // Present one scancode and hold it until it is taken
  task automatic send_scancode(input byte_t code);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= code;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic drain_keys();
    s_axis_tvalid_i <= 1'b0;
    repeat (SettleCycles) @(posedge clk_i);
    while (pending_keys.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic test_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  endtask

  // Field extremes, release codes, modifiers, locks and num lock priority
  task automatic test_special_keys();
    byte_t codes [$];
    codes = '{8'd0, ScEscape, ScSpace, 8'd127, ScFirstFree, ReleaseBit, 8'd255, ExtPrefix,
              ScCtrl, ScAlt, ScLShift, ScQ, ScLShiftUp, ScQ, ScRShift, ScOne, ScRShiftUp,
              ScCaps, ScSlash, ScQ, ScCaps, ScNum, ScPad7, ScLShift, ScPadDot,
              ScLShiftUp, ScNum};
    foreach (codes[i]) send_scancode(codes[i]);
    drain_keys();
  endtask

  // Mostly ordinary key presses, with modifiers, locks and releases mixed in
  function automatic byte_t random_scancode();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) return $urandom_range(1) ? ScLShift : ScRShift;
    if (pick < 16) return $urandom_range(1) ? ScLShiftUp : ScRShiftUp;
    if (pick < 20) return ScCaps;
    if (pick < 24) return ScNum;
    if (pick < 27) return $urandom_range(1) ? ScCtrl : ScAlt;
    if (pick < 40) return byte_t'($urandom_range(255, 128));
    return byte_t'($urandom_range(127));
  endfunction

  task automatic test_random_typing(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (ItemsPerPhase) send_scancode(random_scancode());
    drain_keys();
  endtask

  initial begin
    test_reset();
    test_special_keys();
    test_random_typing(0, 0);
    test_random_typing(72, 0);
    test_random_typing(0, 72);
    test_random_typing(13, 13);
    if (key_errors == 0) begin
      $display("[scancode_to_ascii_translator] OK");
    end else begin
      $display("[scancode_to_ascii_translator] ERROR");
    end
    $finish;
  end

endmodule
